[rtl/comb_rank_pkg.sv]
// Shared types, constants, microcode table and digit divider for the combination rank block.
`default_nettype none

package comb_rank_pkg;

    localparam int RANK_W   = 64;
    localparam int SIZE_W   = 3;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 4;
    localparam int STEP_W   = 4;
    localparam int HALF_W   = 32;

    typedef logic [STEP_W-1:0] step_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_TOO_MANY,
        ST_NOT_ASC,
        ST_OVERFLOW
    } status_t;

    typedef enum logic [3:0] {
        OP_ACCEPT,
        OP_CHECK,
        OP_NOP,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_DIV,
        OP_DIV_END,
        OP_SUM,
        OP_FINISH
    } op_t;

    typedef enum logic [2:0] {
        COND_NONE,
        COND_NO_INPUT,
        COND_REJECT,
        COND_NO_TERM,
        COND_DIV_MORE,
        COND_BIN_DONE,
        COND_OUT_BLOCKED
    } cond_t;

    typedef struct packed {
        logic no_input;
        logic reject;
        logic no_term;
        logic div_more;
        logic bin_done;
        logic out_blocked;
    } cond_flags_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t jump_step;
        step_t next_step;
    } ucode_t;

    localparam step_t S_ACCEPT  = 4'd0;
    localparam step_t S_CHECK   = 4'd1;
    localparam step_t S_TEST    = 4'd2;
    localparam step_t S_MUL_LO  = 4'd3;
    localparam step_t S_MUL_HI  = 4'd4;
    localparam step_t S_DIV     = 4'd5;
    localparam step_t S_DIV_END = 4'd6;
    localparam step_t S_SUM     = 4'd7;
    localparam step_t S_FINISH  = 4'd8;

    function automatic ucode_t ucode_rom(input step_t addr);
        ucode_t w;
        case (addr)
            S_ACCEPT:  w = '{op: OP_ACCEPT,  cond: COND_NO_INPUT,
                             jump_step: S_ACCEPT,  next_step: S_CHECK};
            S_CHECK:   w = '{op: OP_CHECK,   cond: COND_REJECT,
                             jump_step: S_FINISH,  next_step: S_TEST};
            S_TEST:    w = '{op: OP_NOP,     cond: COND_NO_TERM,
                             jump_step: S_SUM,     next_step: S_MUL_LO};
            S_MUL_LO:  w = '{op: OP_MUL_LO,  cond: COND_NONE,
                             jump_step: S_MUL_LO,  next_step: S_MUL_HI};
            S_MUL_HI:  w = '{op: OP_MUL_HI,  cond: COND_NONE,
                             jump_step: S_MUL_HI,  next_step: S_DIV};
            S_DIV:     w = '{op: OP_DIV,     cond: COND_DIV_MORE,
                             jump_step: S_DIV,     next_step: S_DIV_END};
            S_DIV_END: w = '{op: OP_DIV_END, cond: COND_BIN_DONE,
                             jump_step: S_SUM,     next_step: S_MUL_LO};
            S_SUM:     w = '{op: OP_SUM,     cond: COND_NONE,
                             jump_step: S_SUM,     next_step: S_FINISH};
            S_FINISH:  w = '{op: OP_FINISH,  cond: COND_OUT_BLOCKED,
                             jump_step: S_FINISH,  next_step: S_ACCEPT};
            default:   w = '{op: OP_NOP,     cond: COND_NONE,
                             jump_step: S_ACCEPT,  next_step: S_ACCEPT};
        endcase
        return w;
    endfunction

    // Divide {rem, byte} by d (1..8), rem < d; returns {quotient byte, remainder}.
    function automatic logic [10:0] small_div(
        input logic [3:0] d,
        input logic [2:0] rem,
        input logic [7:0] byte_in
    );
        logic [3:0] part;
        logic [4:0] trial;
        logic [7:0] q;
        part = {1'b0, rem};
        q    = '0;
        for (int b = 7; b >= 0; b--)
        begin
            trial = {part, byte_in[b]};
            if (trial >= {1'b0, d})
            begin
                trial = trial - {1'b0, d};
                q[b]  = 1'b1;
            end
            part = trial[3:0];
        end
        return {q, part[2:0]};
    endfunction

endpackage

`default_nettype wire

[rtl/comb_rank_if.sv]
// Element input and rank result channel interfaces.
`default_nettype none

interface comb_rank_in_if #(
    parameter int INDEX_BITS = 12
) ();
    logic                  valid;
    logic                  ready;
    logic [INDEX_BITS-1:0] element_index;
    logic                  last_element;

    modport source (output valid, output element_index, output last_element, input ready);
    modport sink   (input valid, input element_index, input last_element, output ready);
endinterface

interface comb_rank_out_if ();
    logic                                valid;
    logic                                ready;
    logic [comb_rank_pkg::RANK_W-1:0]    rank;
    logic [comb_rank_pkg::SIZE_W-1:0]    set_size;
    logic [comb_rank_pkg::STATUS_W-1:0]  status;

    modport source (output valid, output rank, output set_size, output status, input ready);
    modport sink   (input valid, input rank, input set_size, input status, output ready);
endinterface

`default_nettype wire

[rtl/combination_rank_top.sv]
// Top level of the combination rank block: sequencer, datapath and checks.
`default_nettype none

// Ranks a sorted set in the combinatorial number system. Send the set's element
// indices one per transfer, strictly ascending, with last_element on the final one;
// that transfer yields one result with the colex rank (saturated past 64 bits), the
// number of elements ranked and a status. An element is processed by a microcoded
// sequence around a 32 x INDEX_BITS multiply of each rank half and a byte-serial exact
// divider: a rejected element goes from acceptance through the check step to the finish
// step, an element with index below its position skips from the test step to the sum
// step, and any other element runs a multiply-low, multiply-high, byte-serial divide and
// divide-end pass for each binomial factor before the sum and finish steps.
// One element is in work at a time; a finished result waits in the output register
// while the next element is taken in.
module combination_rank_top #(
    parameter int MAX_ELEMENTS = 6,
    parameter int INDEX_BITS   = 12
) (
    input  logic            clk,
    input  logic            rst_n,
    comb_rank_in_if.sink    item,
    comb_rank_out_if.source result
);
    import comb_rank_pkg::*;

    op_t         op;
    cond_flags_t flags;

    comb_rank_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .op    (op)
    );

    comb_rank_dp #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .INDEX_BITS   (INDEX_BITS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .op     (op),
        .flags  (flags),
        .item   (item),
        .result (result)
    );

`ifndef SYNTHESIS
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |=> !item.ready)
        else $error("input taken twice in a row");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(op == OP_FINISH))
        else $error("result raised outside the finish step");

    a_overflow_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.status == ST_OVERFLOW)) |-> (result.rank == '1))
        else $error("overflow result not saturated");
`endif

endmodule

`default_nettype wire

[rtl/comb_rank_seq.sv]
// Microcode sequencer: step counter, control table lookup and conditional jumps.
`default_nettype none

module comb_rank_seq (
    input  logic                       clk,
    input  logic                       rst_n,
    input  comb_rank_pkg::cond_flags_t flags,
    output comb_rank_pkg::op_t         op
);
    import comb_rank_pkg::*;

    step_t  step_reg;
    step_t  step_next;
    ucode_t word;
    logic   take_jump;

    always_comb
    begin
        word = ucode_rom(step_reg);
        case (word.cond)
            COND_NONE:        take_jump = 1'b0;
            COND_NO_INPUT:    take_jump = flags.no_input;
            COND_REJECT:      take_jump = flags.reject;
            COND_NO_TERM:     take_jump = flags.no_term;
            COND_DIV_MORE:    take_jump = flags.div_more;
            COND_BIN_DONE:    take_jump = flags.bin_done;
            COND_OUT_BLOCKED: take_jump = flags.out_blocked;
            default:          take_jump = 1'b0;
        endcase
        step_next = take_jump ? word.jump_step : word.next_step;
    end

    assign op = word.op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_ACCEPT;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

[rtl/comb_rank_dp.sv]
// Datapath: half-by-half multiplies, byte-serial exact divider, rank accumulator and result register.
`default_nettype none

module comb_rank_dp #(
    parameter int MAX_ELEMENTS = 6,
    parameter int INDEX_BITS   = 12
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  comb_rank_pkg::op_t          op,
    output comb_rank_pkg::cond_flags_t  flags,
    comb_rank_in_if.sink                item,
    comb_rank_out_if.source             result
);
    import comb_rank_pkg::*;

    localparam int PW     = ((RANK_W + INDEX_BITS + 7) / 8) * 8;
    localparam int DIGITS = PW / 8;
    localparam int CNT_W  = $clog2(DIGITS);
    localparam int LO_W   = HALF_W + INDEX_BITS;

    logic [INDEX_BITS-1:0] e_reg, e_next;
    logic [INDEX_BITS-1:0] prev_reg, prev_next;
    logic [INDEX_BITS-1:0] mult_op;
    logic                  last_reg, last_next;
    logic [RANK_W-1:0]     acc_reg, acc_next;
    logic [RANK_W-1:0]     sum_reg, sum_next;
    logic [LO_W-1:0]       part_reg, part_next;
    logic [LO_W-1:0]       hi_prod;
    logic [PW-1:0]         prod_reg, prod_next;
    logic [PW-1:0]         quot_reg, quot_next;
    logic [2:0]            rem_reg, rem_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [2:0]            j_reg, j_next;
    logic                  ovf_reg, ovf_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [POS_W-1:0]      term_k;
    status_t               err_reg, err_next;
    logic                  out_valid_reg, out_valid_next;
    logic [RANK_W-1:0]     rank_reg, rank_next;
    logic [SIZE_W-1:0]     size_reg, size_next;
    status_t               status_reg, status_next;
    logic [3:0]            divisor;
    logic [10:0]           div_res;
    logic [RANK_W:0]       sum_wide;
    logic                  too_many;
    logic                  not_asc;
    logic                  quot_ovf;
    logic                  load_out;

    assign term_k   = pos_reg + POS_W'(1);
    assign too_many = pos_reg >= POS_W'(MAX_ELEMENTS);
    assign not_asc  = (pos_reg != '0) && (e_reg <= prev_reg);
    assign mult_op  = e_reg - INDEX_BITS'(j_reg);
    assign hi_prod  = acc_reg[RANK_W-1:HALF_W] * mult_op;
    assign divisor  = {1'b0, j_reg} + 4'd1;
    assign div_res  = small_div(divisor, rem_reg, prod_reg[PW-1 -: 8]);
    assign quot_ovf = |quot_reg[PW-1:RANK_W];
    assign sum_wide = {1'b0, sum_reg} + {1'b0, acc_reg};

    assign flags.no_input    = !item.valid;
    assign flags.reject      = (err_reg != ST_OK) || too_many || not_asc;
    assign flags.no_term     = e_reg < INDEX_BITS'(term_k);
    assign flags.div_more    = cnt_reg != CNT_W'(DIGITS - 1);
    assign flags.bin_done    = quot_ovf || ({1'b0, j_reg} == pos_reg);
    assign flags.out_blocked = last_reg && out_valid_reg && !result.ready;

    assign load_out   = (op == OP_FINISH) && last_reg && !flags.out_blocked;
    assign item.ready = (op == OP_ACCEPT);

    assign result.valid    = out_valid_reg;
    assign result.rank     = rank_reg;
    assign result.set_size = size_reg;
    assign result.status   = status_reg;

    always_comb
    begin
        e_next      = e_reg;
        last_next   = last_reg;
        prev_next   = prev_reg;
        acc_next    = acc_reg;
        sum_next    = sum_reg;
        part_next   = part_reg;
        prod_next   = prod_reg;
        quot_next   = quot_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        j_next      = j_reg;
        ovf_next    = ovf_reg;
        pos_next    = pos_reg;
        err_next    = err_reg;
        rank_next   = rank_reg;
        size_next   = size_reg;
        status_next = status_reg;
        case (op)
            OP_ACCEPT:
            begin
                if (item.valid)
                begin
                    e_next    = item.element_index;
                    last_next = item.last_element;
                end
            end
            OP_CHECK:
            begin
                if (err_reg == ST_OK)
                begin
                    if (too_many)
                    begin
                        err_next = ST_TOO_MANY;
                    end
                    else if (not_asc)
                    begin
                        err_next = ST_NOT_ASC;
                    end
                end
                acc_next = flags.no_term ? '0 : RANK_W'(1);
                j_next   = '0;
                ovf_next = 1'b0;
            end
            OP_MUL_LO:
            begin
                part_next = acc_reg[HALF_W-1:0] * mult_op;
            end
            OP_MUL_HI:
            begin
                prod_next = PW'({hi_prod, {HALF_W{1'b0}}}) + PW'(part_reg);
                cnt_next  = '0;
                rem_next  = '0;
            end
            OP_DIV:
            begin
                quot_next = {quot_reg[PW-9:0], div_res[10:3]};
                prod_next = {prod_reg[PW-9:0], 8'h00};
                rem_next  = div_res[2:0];
                cnt_next  = cnt_reg + CNT_W'(1);
            end
            OP_DIV_END:
            begin
                if (quot_ovf)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    acc_next = quot_reg[RANK_W-1:0];
                    j_next   = j_reg + 3'd1;
                end
            end
            OP_SUM:
            begin
                if (ovf_reg || sum_wide[RANK_W])
                begin
                    sum_next = '1;
                    err_next = ST_OVERFLOW;
                end
                else
                begin
                    sum_next = sum_wide[RANK_W-1:0];
                end
                pos_next  = term_k;
                prev_next = e_reg;
            end
            OP_FINISH:
            begin
                if (load_out)
                begin
                    rank_next   = sum_reg;
                    size_next   = pos_reg[SIZE_W-1:0];
                    status_next = err_reg;
                    pos_next    = '0;
                    sum_next    = '0;
                    prev_next   = '0;
                    err_next    = ST_OK;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            sum_reg       <= '0;
            prev_reg      <= '0;
            err_reg       <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            prev_reg      <= prev_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg      <= e_next;
        last_reg   <= last_next;
        acc_reg    <= acc_next;
        part_reg   <= part_next;
        prod_reg   <= prod_next;
        quot_reg   <= quot_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        j_reg      <= j_next;
        ovf_reg    <= ovf_next;
        rank_reg   <= rank_next;
        size_reg   <= size_next;
        status_reg <= status_next;
    end

endmodule

`default_nettype wire
